[rtl/sck_pkg.sv]
// Shared constants and register index codes for the cubic spline kernel block.
package sck_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned EPS_W         = 16;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned AXES          = 3;

  localparam logic [DATA_W-1:0] SMOOTHING_LENGTH_RST = 32'd65536;
  localparam logic [DATA_W-1:0] KERNEL_SCALE_RST     = 32'd31291;
  localparam logic [EPS_W-1:0]  GRADIENT_EPSILON_RST = 16'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SMOOTHING_LENGTH = 2'd0,
    CFG_KERNEL_SCALE     = 2'd1,
    CFG_GRADIENT_EPSILON = 2'd2
  } cfg_idx_e;

endpackage

[rtl/sck_sqrt_cell.sv]
// One restoring square root step: two radicand bits in, one root bit out.
module sck_sqrt_cell #(
  parameter int unsigned RW = 32,
  parameter int unsigned SW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*RW-1:0]   rad_i,
  input  logic [RW+1:0]     rem_i,
  input  logic [RW-1:0]     root_i,
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output logic [2*RW-1:0]   rad_o,
  output logic [RW+1:0]     rem_o,
  output logic [RW-1:0]     root_o,
  output logic [SW-1:0]     side_o
);

  logic [RW+3:0] rem2;
  logic [RW+3:0] trial;
  logic [RW+3:0] diff;
  logic          ge;
  logic [RW+1:0] rem_d;

  always_comb begin
    rem2  = {rem_i, rad_i[2*RW-1 -: 2]};
    trial = (RW+4)'({root_i, 2'b01});
    diff  = rem2 - trial;
    ge    = (rem2 >= trial);
    rem_d = ge ? diff[RW+1:0] : rem2[RW+1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= {rad_i[2*RW-3:0], 2'b00};
      rem_o  <= rem_d;
      root_o <= {root_i[RW-2:0], ge};
      side_o <= side_i;
    end
  end

endmodule

[rtl/sck_div_cell.sv]
// One restoring division step over several lanes that share a divisor.
module sck_div_cell #(
  parameter int unsigned LANES = 1,
  parameter int unsigned NW    = 8,
  parameter int unsigned DW    = 8,
  parameter int unsigned SW    = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [DW-1:0]              divisor_i,
  input  logic [LANES-1:0][DW-1:0]   rem_i,
  input  logic [LANES-1:0][NW-1:0]   acc_i,
  input  logic [SW-1:0]              side_i,
  output logic                       valid_o,
  output logic [DW-1:0]              divisor_o,
  output logic [LANES-1:0][DW-1:0]   rem_o,
  output logic [LANES-1:0][NW-1:0]   acc_o,
  output logic [SW-1:0]              side_o
);

  logic [LANES-1:0][DW-1:0] rem_d;
  logic [LANES-1:0][NW-1:0] acc_d;

  always_comb begin
    logic [DW:0] rem2;
    logic [DW:0] diff;
    logic        ge;
    for (int l = 0; l < int'(LANES); l++) begin
      rem2     = {rem_i[l], acc_i[l][NW-1]};
      diff     = rem2 - {1'b0, divisor_i};
      ge       = (rem2 >= {1'b0, divisor_i});
      rem_d[l] = ge ? diff[DW-1:0] : rem2[DW-1:0];
      // shift the dividend out at the top, the quotient bit in at the bottom
      acc_d[l] = {acc_i[l][NW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      divisor_o <= divisor_i;
      rem_o     <= rem_d;
      acc_o     <= acc_d;
      side_o    <= side_i;
    end
  end

endmodule

[rtl/sck_div_chain.sv]
// Row of division cells giving one quotient bit per cell for each lane.
module sck_div_chain #(
  parameter int unsigned LANES = 1,
  parameter int unsigned NW    = 8,
  parameter int unsigned DW    = 8,
  parameter int unsigned SW    = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [DW-1:0]              divisor_i,
  input  logic [LANES-1:0][NW-1:0]   dividend_i,
  input  logic [SW-1:0]              side_i,
  output logic                       valid_o,
  output logic [LANES-1:0][NW-1:0]   quotient_o,
  output logic [SW-1:0]              side_o
);

  logic [NW:0]                       v_w;
  logic [NW:0][DW-1:0]               d_w;
  logic [NW:0][LANES-1:0][DW-1:0]    r_w;
  logic [NW:0][LANES-1:0][NW-1:0]    a_w;
  logic [NW:0][SW-1:0]               s_w;

  assign v_w[0] = valid_i;
  assign d_w[0] = divisor_i;
  assign r_w[0] = '0;
  assign a_w[0] = dividend_i;
  assign s_w[0] = side_i;

  for (genvar k = 0; k < NW; k++) begin : g_cell
    sck_div_cell #(
      .LANES(LANES),
      .NW   (NW),
      .DW   (DW),
      .SW   (SW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en_i),
      .valid_i  (v_w[k]),
      .divisor_i(d_w[k]),
      .rem_i    (r_w[k]),
      .acc_i    (a_w[k]),
      .side_i   (s_w[k]),
      .valid_o  (v_w[k+1]),
      .divisor_o(d_w[k+1]),
      .rem_o    (r_w[k+1]),
      .acc_o    (a_w[k+1]),
      .side_o   (s_w[k+1])
    );
  end

  assign valid_o    = v_w[NW];
  assign quotient_o = a_w[NW];
  assign side_o     = s_w[NW];

endmodule

[rtl/sph_cubic_spline_kernel.sv]
// Top level of the 3D cubic spline kernel and gradient pipeline.
// Pipeline, with data in Q16.16 at the default FRAC_BITS:
// 32 square root cells, 33+FRAC_BITS cells for q and the unit vector,
// 32+FRAC_BITS cells for the gradient divide by h, 9 arithmetic stages and the output register.
// Throughput: one request per unstalled cycle; a stalled result holds the output register.
// Reset clears all valid bits and loads the register defaults.
module sph_cubic_spline_kernel #(
  parameter int unsigned FRAC_BITS = sck_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [sck_pkg::DATA_W-1:0]     disp_x_i,
  input  logic signed [sck_pkg::DATA_W-1:0]     disp_y_i,
  input  logic signed [sck_pkg::DATA_W-1:0]     disp_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [sck_pkg::DATA_W-1:0]            kernel_value_o,
  output logic signed [sck_pkg::DATA_W-1:0]     grad_x_o,
  output logic signed [sck_pkg::DATA_W-1:0]     grad_y_o,
  output logic signed [sck_pkg::DATA_W-1:0]     grad_z_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [sck_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [sck_pkg::DATA_W-1:0]            cfg_data_i
);

  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned DW  = sck_pkg::DATA_W;
  localparam int unsigned NA  = sck_pkg::AXES;
  localparam int unsigned RW  = DW;
  localparam int unsigned SQW = NA*DW + NA;
  localparam int unsigned QW  = RW + 1 + F;
  localparam int unsigned GW  = DW + F;
  localparam int unsigned XW  = F + 1;
  localparam int unsigned MW  = DW + XW;
  localparam int unsigned RK  = F + 4;
  localparam int unsigned R6_I = ((2**RK) + 5) / 6;
  localparam int unsigned TT_I = (2**(F+1)) / 3;
  localparam logic [XW:0] FX_TWO = (XW+1)'(2**(F+1));

  // configuration
  logic [DW-1:0]             smoothing_length_q;
  logic [DW-1:0]             kernel_scale_q;
  logic [sck_pkg::EPS_W-1:0] gradient_epsilon_q;
  logic [DW-1:0]             h_eff;

  assign cfg_ready_o = 1'b1;
  assign h_eff = (smoothing_length_q == '0) ? DW'(1) : smoothing_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smoothing_length_q <= sck_pkg::SMOOTHING_LENGTH_RST;
      kernel_scale_q     <= sck_pkg::KERNEL_SCALE_RST;
      gradient_epsilon_q <= sck_pkg::GRADIENT_EPSILON_RST;
    end else if (cfg_valid_i) begin
      unique case (sck_pkg::cfg_idx_e'(cfg_index_i))
        sck_pkg::CFG_SMOOTHING_LENGTH: smoothing_length_q <= cfg_data_i;
        sck_pkg::CFG_KERNEL_SCALE:     kernel_scale_q     <= cfg_data_i;
        sck_pkg::CFG_GRADIENT_EPSILON: gradient_epsilon_q <= cfg_data_i[sck_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance: stall only when the output register holds a stalled result
  // and the last stage has one waiting behind it
  logic adv;
  logic g_v;
  logic out_valid_q;

  assign adv        = !(g_v && out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // stage A: magnitudes and signs
  logic [NA-1:0][DW-1:0] disp_w;
  logic [NA-1:0][DW-1:0] a_mag_d;
  logic [NA-1:0]         a_neg_d;
  logic                  a_v_q;
  logic [NA-1:0][DW-1:0] a_mag_q;
  logic [NA-1:0]         a_neg_q;

  assign disp_w = {$unsigned(disp_z_i), $unsigned(disp_y_i), $unsigned(disp_x_i)};

  always_comb begin
    for (int i = 0; i < int'(NA); i++) begin
      a_neg_d[i] = disp_w[i][DW-1];
      a_mag_d[i] = a_neg_d[i] ? (DW'(0) - disp_w[i]) : disp_w[i];
    end
  end

  // stage B: squares, stage C: sum
  logic                    b_v_q;
  logic [NA-1:0][2*DW-1:0] b_sq_q;
  logic [NA-1:0][DW-1:0]   b_mag_q;
  logic [NA-1:0]           b_neg_q;
  logic                    c_v_q;
  logic [2*DW-1:0]         c_sum_q;
  logic [NA-1:0][DW-1:0]   c_mag_q;
  logic [NA-1:0]           c_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else if (adv) begin
      a_v_q <= in_valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_mag_q <= a_mag_d;
      a_neg_q <= a_neg_d;
      for (int i = 0; i < int'(NA); i++) begin
        b_sq_q[i] <= (2*DW)'(a_mag_q[i]) * (2*DW)'(a_mag_q[i]);
      end
      b_mag_q <= a_mag_q;
      b_neg_q <= a_neg_q;
      c_sum_q <= b_sq_q[0] + b_sq_q[1] + b_sq_q[2];
      c_mag_q <= b_mag_q;
      c_neg_q <= b_neg_q;
    end
  end

  // square root cells
  logic [RW:0]                sq_v_w;
  logic [RW:0][2*RW-1:0]      sq_rad_w;
  logic [RW:0][RW+1:0]        sq_rem_w;
  logic [RW:0][RW-1:0]        sq_root_w;
  logic [RW:0][SQW-1:0]       sq_side_w;

  assign sq_v_w[0]    = c_v_q;
  assign sq_rad_w[0]  = c_sum_q;
  assign sq_rem_w[0]  = '0;
  assign sq_root_w[0] = '0;
  assign sq_side_w[0] = {c_mag_q, c_neg_q};

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    sck_sqrt_cell #(
      .RW(RW),
      .SW(SQW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(sq_v_w[k]),
      .rad_i  (sq_rad_w[k]),
      .rem_i  (sq_rem_w[k]),
      .root_i (sq_root_w[k]),
      .side_i (sq_side_w[k]),
      .valid_o(sq_v_w[k+1]),
      .rad_o  (sq_rad_w[k+1]),
      .rem_o  (sq_rem_w[k+1]),
      .root_o (sq_root_w[k+1]),
      .side_o (sq_side_w[k+1])
    );
  end

  // stage D: shifted distance
  logic                  d_v_q;
  logic [RW-1:0]         d_r_q;
  logic [RW:0]           d_rp_q;
  logic [NA-1:0][DW-1:0] d_mag_q;
  logic [NA-1:0]         d_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else if (adv) begin
      d_v_q <= sq_v_w[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_r_q   <= sq_root_w[RW];
      d_rp_q  <= (RW+1)'(sq_root_w[RW]) + (RW+1)'(gradient_epsilon_q);
      {d_mag_q, d_neg_q} <= sq_side_w[RW];
    end
  end

  // q and q' chain, unit vector chain
  logic [1:0][QW-1:0]     qd_w;
  logic [NA-1:0][QW-1:0]  cd_w;
  logic                   q_v_w;
  logic                   c_v_w;
  logic [1:0][QW-1:0]     q_quo_w;
  logic [NA-1:0][QW-1:0]  c_quo_w;
  logic                   q_rpz_w;
  logic [NA-1:0]          c_neg_w;

  always_comb begin
    qd_w[0] = {1'b0, d_r_q, F'(0)};
    qd_w[1] = {d_rp_q, F'(0)};
    for (int i = 0; i < int'(NA); i++) begin
      cd_w[i] = {1'b0, d_mag_q[i], F'(0)};
    end
  end

  sck_div_chain #(
    .LANES(2),
    .NW   (QW),
    .DW   (DW),
    .SW   (1)
  ) u_q_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (d_v_q),
    .divisor_i (h_eff),
    .dividend_i(qd_w),
    .side_i    (d_rp_q == '0),
    .valid_o   (q_v_w),
    .quotient_o(q_quo_w),
    .side_o    (q_rpz_w)
  );

  sck_div_chain #(
    .LANES(NA),
    .NW   (QW),
    .DW   (RW+1),
    .SW   (NA)
  ) u_c_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (d_v_q),
    .divisor_i (d_rp_q),
    .dividend_i(cd_w),
    .side_i    (d_neg_q),
    .valid_o   (c_v_w),
    .quotient_o(c_quo_w),
    .side_o    (c_neg_w)
  );

  // P1: region flags, base and square
  logic [QW-1:0]   e_qv;
  logic [QW-1:0]   e_qg;
  logic            e_lo_v;
  logic            e_in_v;
  logic            e_lo_g;
  logic            e_in_g;
  logic [XW-1:0]   e_x;
  logic [XW-1:0]   e_xg;
  logic [2*XW-1:0] e_xx;
  logic [2*XW-1:0] e_xxg;

  always_comb begin
    e_qv   = q_quo_w[0];
    e_qg   = q_quo_w[1];
    e_lo_v = (e_qv[QW-1:F] == '0);
    e_in_v = (e_qv[QW-1:F+1] == '0);
    e_lo_g = (e_qg[QW-1:F] == '0) && !q_rpz_w;
    e_in_g = (e_qg[QW-1:F+1] == '0) && !q_rpz_w;
    e_x    = e_lo_v ? e_qv[F:0] : XW'(FX_TWO - {1'b0, e_qv[F:0]});
    e_xg   = e_lo_g ? e_qg[F:0] : XW'(FX_TWO - {1'b0, e_qg[F:0]});
    e_xx   = (2*XW)'(e_x) * (2*XW)'(e_x);
    e_xxg  = (2*XW)'(e_xg) * (2*XW)'(e_xg);
  end

  logic                  p1_v_q;
  logic                  p1_lo_v_q;
  logic                  p1_in_v_q;
  logic                  p1_lo_g_q;
  logic                  p1_in_g_q;
  logic [XW-1:0]         p1_x_q;
  logic [XW-1:0]         p1_sq_q;
  logic [XW-1:0]         p1_xg_q;
  logic [XW-1:0]         p1_sqg_q;
  logic [NA-1:0][XW-1:0] p1_c_q;
  logic [NA-1:0]         p1_neg_q;

  // P2: cube and slope magnitude
  logic [2*XW-1:0]       f_xx;
  logic [F+2:0]          f_three_sq;
  logic signed [F+3:0]   f_mdiff;
  logic [XW-1:0]         f_m;

  always_comb begin
    f_xx       = (2*XW)'(p1_sq_q) * (2*XW)'(p1_x_q);
    f_three_sq = (F+3)'({p1_sqg_q, 1'b0}) + (F+3)'(p1_sqg_q);
    f_mdiff    = $signed((F+4)'({p1_xg_q, 1'b0})) - $signed((F+4)'(f_three_sq >> 1));
    priority if (p1_lo_g_q) begin
      f_m = f_mdiff[F+3] ? '0 : f_mdiff[F:0];
    end else if (p1_in_g_q) begin
      f_m = p1_sqg_q >> 1;
    end else begin
      f_m = '0;
    end
  end

  logic                  p2_v_q;
  logic                  p2_lo_v_q;
  logic                  p2_in_v_q;
  logic [XW-1:0]         p2_sq_q;
  logic [XW-1:0]         p2_cube_q;
  logic [XW-1:0]         p2_m_q;
  logic [NA-1:0][XW-1:0] p2_c_q;
  logic [NA-1:0]         p2_neg_q;

  // P3: inner spline value, divide-by-six product, scaled slope
  logic signed [F+2:0] h_sdiff;
  logic [MW-1:0]       h_mm;

  always_comb begin
    h_sdiff = $signed((F+3)'(TT_I)) - $signed((F+3)'(p2_sq_q))
              + $signed((F+3)'(p2_cube_q >> 1));
    h_mm    = MW'(kernel_scale_q) * MW'(p2_m_q);
  end

  logic                  p3_v_q;
  logic                  p3_lo_v_q;
  logic                  p3_in_v_q;
  logic [XW-1:0]         p3_s_lo_q;
  logic [XW+RK-1:0]      p3_prod6_q;
  logic [DW-1:0]         p3_big_m_q;
  logic [NA-1:0][XW-1:0] p3_c_q;
  logic [NA-1:0]         p3_neg_q;

  // P4: spline value select, gradient numerators
  logic [XW-1:0]         j_s;
  logic [NA-1:0][MW-1:0] j_pp;

  always_comb begin
    priority if (p3_lo_v_q) begin
      j_s = p3_s_lo_q;
    end else if (p3_in_v_q) begin
      j_s = p3_prod6_q[XW+RK-1:RK];
    end else begin
      j_s = '0;
    end
    for (int i = 0; i < int'(NA); i++) begin
      j_pp[i] = MW'(p3_c_q[i]) * MW'(p3_big_m_q);
    end
  end

  logic                  p4_v_q;
  logic [XW-1:0]         p4_s_q;
  logic [NA-1:0][DW-1:0] p4_p_q;
  logic [NA-1:0]         p4_neg_q;

  // P5: kernel value
  logic [MW-1:0] k_ws;

  assign k_ws = MW'(kernel_scale_q) * MW'(p4_s_q);

  logic                  p5_v_q;
  logic [DW-1:0]         p5_w_q;
  logic [NA-1:0][DW-1:0] p5_p_q;
  logic [NA-1:0]         p5_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
      p5_v_q <= 1'b0;
    end else if (adv) begin
      p1_v_q <= q_v_w && c_v_w;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
      p4_v_q <= p3_v_q;
      p5_v_q <= p4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_lo_v_q <= e_lo_v;
      p1_in_v_q <= e_in_v;
      p1_lo_g_q <= e_lo_g;
      p1_in_g_q <= e_in_g;
      p1_x_q    <= e_x;
      p1_sq_q   <= e_xx[2*F:F];
      p1_xg_q   <= e_xg;
      p1_sqg_q  <= e_xxg[2*F:F];
      for (int i = 0; i < int'(NA); i++) begin
        p1_c_q[i] <= c_quo_w[i][F:0];
      end
      p1_neg_q  <= c_neg_w;

      p2_lo_v_q <= p1_lo_v_q;
      p2_in_v_q <= p1_in_v_q;
      p2_sq_q   <= p1_sq_q;
      p2_cube_q <= f_xx[2*F:F];
      p2_m_q    <= f_m;
      p2_c_q    <= p1_c_q;
      p2_neg_q  <= p1_neg_q;

      p3_lo_v_q  <= p2_lo_v_q;
      p3_in_v_q  <= p2_in_v_q;
      p3_s_lo_q  <= h_sdiff[F+2] ? '0 : h_sdiff[F:0];
      p3_prod6_q <= (XW+RK)'(p2_cube_q) * (XW+RK)'(R6_I);
      p3_big_m_q <= h_mm[F+DW-1:F];
      p3_c_q     <= p2_c_q;
      p3_neg_q   <= p2_neg_q;

      p4_s_q <= j_s;
      for (int i = 0; i < int'(NA); i++) begin
        p4_p_q[i] <= j_pp[i][F+DW-1:F];
      end
      p4_neg_q <= p3_neg_q;

      p5_w_q   <= k_ws[F+DW] ? '1 : k_ws[F+DW-1:F];
      p5_p_q   <= p4_p_q;
      p5_neg_q <= p4_neg_q;
    end
  end

  // gradient divide by h
  logic [NA-1:0][GW-1:0] gd_w;
  logic [NA-1:0][GW-1:0] g_quo_w;
  logic [DW-1:0]         g_w_w;
  logic [NA-1:0]         g_neg_w;

  always_comb begin
    for (int i = 0; i < int'(NA); i++) begin
      gd_w[i] = {p5_p_q[i], F'(0)};
    end
  end

  sck_div_chain #(
    .LANES(NA),
    .NW   (GW),
    .DW   (DW),
    .SW   (DW+NA)
  ) u_g_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (p5_v_q),
    .divisor_i (h_eff),
    .dividend_i(gd_w),
    .side_i    ({p5_w_q, p5_neg_q}),
    .valid_o   (g_v),
    .quotient_o(g_quo_w),
    .side_o    ({g_w_w, g_neg_w})
  );

  // sign and saturate; the gradient points against the displacement
  logic [NA-1:0][DW-1:0] o_grad;

  always_comb begin
    for (int i = 0; i < int'(NA); i++) begin
      if (g_neg_w[i]) begin
        o_grad[i] = (g_quo_w[i][GW-1:DW-1] != '0) ? {1'b0, {(DW-1){1'b1}}}
                                                   : g_quo_w[i][DW-1:0];
      end else if ((g_quo_w[i][GW-1:DW] != '0)
                   || (g_quo_w[i][DW-1] && (g_quo_w[i][DW-2:0] != '0))) begin
        o_grad[i] = {1'b1, {(DW-1){1'b0}}};
      end else begin
        o_grad[i] = DW'(0) - g_quo_w[i][DW-1:0];
      end
    end
  end

  logic [DW-1:0]         out_w_q;
  logic [NA-1:0][DW-1:0] out_g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= g_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_w_q <= g_w_w;
      out_g_q <= o_grad;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kernel_value_o = out_w_q;
  assign grad_x_o       = $signed(out_g_q[0]);
  assign grad_y_o       = $signed(out_g_q[1]);
  assign grad_z_o       = $signed(out_g_q[2]);

endmodule
